### hdl/hashed_pair_sum_finder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the hashed pair sum finder.
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef HASHED_PAIR_SUM_FINDER_MACROS_SVH
`define HASHED_PAIR_SUM_FINDER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every edge outside reset.
`define HPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property whose consequent must hold in the cycle after the antecedent.
`define HPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HPS_ASSERT(lbl, prop, msg)
`define HPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/hpsf_pkg.sv
// ---------------------------------------------------------------------------
// Hashed pair sum finder package
// Fixed widths, hash reduction constants and result status codes.
// ---------------------------------------------------------------------------
package hpsf_pkg;

  // Width of one data word and of target minus value.
  localparam int VAL_W  = 32;
  localparam int NEED_W = 33;

  // Bucket reduction: magnitude bits folded into the remainder per cycle.
  localparam int HASH_STEP = 4;
  localparam int HASH_CYC  = (NEED_W + HASH_STEP - 1) / HASH_STEP;
  localparam int HASH_W    = HASH_CYC * HASH_STEP;
  localparam int HCNT_W    = $clog2(HASH_CYC);

  // Set tag stored with every bucket head.
  localparam int EPOCH_W = 8;

  // Reported index width.
  localparam int IDX_OUT_W = 10;

  typedef logic [1:0] status_t;

  localparam status_t ST_NONE   = 2'd0;
  localparam status_t ST_PAIR   = 2'd1;
  localparam status_t ST_END    = 2'd2;
  localparam status_t ST_IGNORE = 2'd3;

endpackage

### hdl/hashed_pair_sum_finder.sv
// ---------------------------------------------------------------------------
// Hashed pair sum finder
// Chained hash table over one set of signed words that reports the first
// pair whose sum equals the configured target.
// ---------------------------------------------------------------------------
// One word is processed at a time and gives one result word. A word that is
// stored or matched passes through the bucket reduction, the head read and a
// walk of its chain; an ignored word skips them. The bucket reduction folds 4
// magnitude bits per cycle into the remainders, and the node memory's single
// read port visits one chain node per cycle. Bucket heads carry a set tag so
// a new set starts without clearing them; a clearing pass over all BUCKETS
// heads runs after reset and again on the first word of every 256th set,
// during which no word is taken. A finished result waits in the output
// register while the next word is taken.
// ---------------------------------------------------------------------------
module hashed_pair_sum_finder
  import hpsf_pkg::*;
#(
  parameter int MAX_ITEMS = 1024,
  parameter int BUCKETS   = 2047
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration
  input  logic                 cfg_wr_en,
  input  logic [VAL_W-1:0]     cfg_wr_data,
  // Input words
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VAL_W-1:0]     in_value,
  input  logic                 in_first_of_set,
  input  logic                 in_last_of_set,
  // Result words
  output logic                 out_valid,
  input  logic                 out_ready,
  output status_t              out_status,
  output logic [IDX_OUT_W-1:0] out_earlier_index,
  output logic [IDX_OUT_W-1:0] out_later_index
);

  `include "hashed_pair_sum_finder_macros.svh"

  // Derived widths.
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int BENT_W = EPOCH_W + CNT_W;
  localparam int NENT_W = VAL_W + CNT_W;
  localparam logic [BKT_W:0] BKT_C = (BKT_W + 1)'(BUCKETS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EVAL, S_HASH, S_HREQ, S_HEAD, S_WALK, S_PREQ, S_PUSH, S_FIN
  } state_t;

  // Memories: bucket heads with set tag, nodes with value and next link.
  logic [BENT_W-1:0] bkt_mem [BUCKETS];
  logic [NENT_W-1:0] node_mem [MAX_ITEMS];

  state_t               state_r;
  logic [VAL_W-1:0]     target_r;
  logic [EPOCH_W-1:0]   epoch_r;
  logic                 pend_r;
  logic [BKT_W-1:0]     clr_idx_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 solved_r;
  logic [VAL_W-1:0]     value_r;
  logic                 last_r;
  logic [NEED_W-1:0]    need_r;
  logic [HASH_W-1:0]    msh_r;
  logic [HASH_W-1:0]    vsh_r;
  logic [BKT_W-1:0]     rn_r;
  logic [BKT_W-1:0]     rv_r;
  logic [HCNT_W-1:0]    hcnt_r;
  logic [CNT_W-1:0]     link_r;
  status_t              res_status_r;
  logic [IDX_OUT_W-1:0] res_earlier_r;
  logic [IDX_OUT_W-1:0] res_later_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [IDX_OUT_W-1:0] out_earlier_r;
  logic [IDX_OUT_W-1:0] out_later_r;
  logic [BENT_W-1:0]    bkt_rdata_r;
  logic [NENT_W-1:0]    node_rdata_r;

  logic [BKT_W-1:0]  rn_nxt;
  logic [BKT_W-1:0]  rv_nxt;
  logic [BKT_W:0]    tn;
  logic [BKT_W:0]    tv;
  logic [NEED_W-1:0] need_full;
  logic [NEED_W-1:0] need_mag;
  logic [NEED_W-1:0] val_ext;
  logic [NEED_W-1:0] val_mag;
  logic [CNT_W-1:0]  head_link;
  logic [CNT_W-1:0]  node_next;
  logic [VAL_W-1:0]  node_val;
  logic              node_hit;
  logic              bkt_re;
  logic [BKT_W-1:0]  bkt_raddr;
  logic              bkt_we;
  logic [BKT_W-1:0]  bkt_waddr;
  logic [BENT_W-1:0] bkt_wdata;
  logic              node_re;
  logic [CNT_W-1:0]  node_rlink;
  logic              out_free;

  // Target minus value and both magnitudes, all at 33 bits.
  always_comb begin
    val_ext   = {value_r[VAL_W-1], value_r};
    need_full = {target_r[VAL_W-1], target_r} - val_ext;
    need_mag  = need_full[NEED_W-1] ? (~need_full + 1'b1) : need_full;
    val_mag   = val_ext[NEED_W-1] ? (~val_ext + 1'b1) : val_ext;
  end

  // Bucket reduction: fold the next magnitude bits into both remainders.
  always_comb begin
    rn_nxt = rn_r;
    rv_nxt = rv_r;
    tn     = '0;
    tv     = '0;
    for (int i = 0; i < HASH_STEP; i++) begin
      tn = {rn_nxt, msh_r[HASH_W-1-i]};
      tv = {rv_nxt, vsh_r[HASH_W-1-i]};
      if (tn >= BKT_C) begin
        tn = tn - BKT_C;
      end
      if (tv >= BKT_C) begin
        tv = tv - BKT_C;
      end
      rn_nxt = tn[BKT_W-1:0];
      rv_nxt = tv[BKT_W-1:0];
    end
  end

  // A bucket head from an older set reads as empty.
  assign head_link = (bkt_rdata_r[BENT_W-1:CNT_W] == epoch_r) ? bkt_rdata_r[CNT_W-1:0] : '0;
  assign node_val  = node_rdata_r[NENT_W-1:CNT_W];
  assign node_next = node_rdata_r[CNT_W-1:0];
  // A need outside the 32-bit range never matches a stored word.
  assign node_hit  = (need_r[NEED_W-1] == need_r[VAL_W-1]) && (node_val == need_r[VAL_W-1:0]);

  // Memory port control.
  always_comb begin
    bkt_re     = (state_r == S_HREQ) || (state_r == S_PREQ);
    bkt_raddr  = (state_r == S_HREQ) ? rn_r : rv_r;
    bkt_we     = 1'b0;
    bkt_waddr  = clr_idx_r;
    bkt_wdata  = '0;
    node_re    = 1'b0;
    node_rlink = head_link;
    unique case (state_r)
      S_CLEAR: begin
        bkt_we = 1'b1;
      end
      S_PUSH: begin
        bkt_we    = 1'b1;
        bkt_waddr = rv_r;
        bkt_wdata = {epoch_r, cnt_r + 1'b1};
      end
      S_HEAD: begin
        node_re = (head_link != '0);
      end
      S_WALK: begin
        node_re    = !node_hit && (node_next != '0);
        node_rlink = node_next;
      end
      default: begin
      end
    endcase
  end

  // Bucket head memory.
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (bkt_re) begin
      bkt_rdata_r <= bkt_mem[bkt_raddr];
    end
  end

  // Node memory.
  logic [CNT_W-1:0] node_raddr;
  assign node_raddr = node_rlink - 1'b1;

  always_ff @(posedge clk) begin
    if (state_r == S_PUSH) begin
      node_mem[cnt_r[IDX_W-1:0]] <= {value_r, head_link};
    end
    if (node_re) begin
      node_rdata_r <= node_mem[node_raddr[IDX_W-1:0]];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Sequencer, counters and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      target_r    <= '0;
      epoch_r     <= '0;
      pend_r      <= 1'b0;
      clr_idx_r   <= '0;
      cnt_r       <= '0;
      solved_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == BKT_LAST) begin
            clr_idx_r <= '0;
            pend_r    <= 1'b0;
            state_r   <= pend_r ? S_EVAL : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            value_r <= in_value;
            last_r  <= in_last_of_set;
            state_r <= S_EVAL;
            if (in_first_of_set) begin
              cnt_r    <= '0;
              solved_r <= 1'b0;
              if (epoch_r == '1) begin
                // Tags are exhausted: wipe the heads before this word.
                epoch_r <= '0;
                pend_r  <= 1'b1;
                state_r <= S_CLEAR;
              end else begin
                epoch_r <= epoch_r + 1'b1;
              end
            end
          end
        end
        S_EVAL: begin
          res_earlier_r <= '0;
          res_later_r   <= '0;
          msh_r         <= HASH_W'(need_mag);
          vsh_r         <= HASH_W'(val_mag);
          need_r        <= need_full;
          rn_r          <= '0;
          rv_r          <= '0;
          hcnt_r        <= '0;
          priority if (solved_r) begin
            res_status_r <= ST_IGNORE;
            state_r      <= S_FIN;
          end else if (cnt_r == CNT_MAX) begin
            res_status_r <= last_r ? ST_END : ST_IGNORE;
            solved_r     <= last_r;
            state_r      <= S_FIN;
          end else begin
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          rn_r   <= rn_nxt;
          rv_r   <= rv_nxt;
          msh_r  <= msh_r << HASH_STEP;
          vsh_r  <= vsh_r << HASH_STEP;
          hcnt_r <= hcnt_r + 1'b1;
          if (hcnt_r == HCNT_W'(HASH_CYC - 1)) begin
            state_r <= S_HREQ;
          end
        end
        S_HREQ: begin
          state_r <= S_HEAD;
        end
        S_HEAD: begin
          link_r  <= head_link;
          state_r <= (head_link != '0) ? S_WALK : S_PREQ;
        end
        S_WALK: begin
          priority if (node_hit) begin
            res_status_r  <= ST_PAIR;
            res_earlier_r <= IDX_OUT_W'(link_r - 1'b1);
            res_later_r   <= IDX_OUT_W'(cnt_r);
            solved_r      <= 1'b1;
            state_r       <= S_FIN;
          end else if (node_next == '0) begin
            state_r <= S_PREQ;
          end else begin
            link_r <= node_next;
          end
        end
        S_PREQ: begin
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          cnt_r        <= cnt_r + 1'b1;
          res_status_r <= last_r ? ST_END : ST_NONE;
          solved_r     <= last_r;
          state_r      <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_earlier_r <= res_earlier_r;
            out_later_r   <= res_later_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_earlier_index = out_earlier_r;
  assign out_later_index   = out_later_r;

  // The node count never runs past capacity.
  `HPS_ASSERT(a_cnt_bound, cnt_r <= CNT_MAX, "node count beyond capacity")
  // A walked node is always a real node.
  `HPS_ASSERT(a_walk_link, (state_r != S_WALK) || (link_r != '0), "walk on empty link")
  // Every push adds exactly one node.
  `HPS_ASSERT_NEXT(a_push_cnt, state_r == S_PUSH, cnt_r == $past(cnt_r) + 1'b1,
                   "push did not advance node count")
  // A finished result is held while the output register is still taken.
  `HPS_ASSERT_NEXT(a_fin_hold, (state_r == S_FIN) && out_valid_r && !out_ready,
                   (state_r == S_FIN) && out_valid_r, "result overwrote a waiting word")

endmodule

### tb/tb_hashed_pair_sum_finder.sv
// ---------------------------------------------------------------------------
// Hashed pair sum finder testbench
// Feeds sets of signed words through the valid/ready input channel and checks
// every result word against a typed row result or a model of the chained hash
// table. A directed table covers reset, extreme targets and words, closed sets
// and chain collisions. Random traffic follows: a burst of one-word sets, one
// set past capacity, then short sets with planted pairs and noisy set markers.
// ---------------------------------------------------------------------------
module tb_hashed_pair_sum_finder
  import hpsf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_CAP      = 1024;
  localparam int BUCKET_CNT   = 2047;
  localparam int WORD_BUDGET  = 1750;
  localparam int QUIET_LIMIT  = 20000;
  localparam int BIG_SET_LEN  = 1030;
  localparam int SINGLE_SETS  = 300;

  typedef struct packed {
    status_t              status;
    logic [IDX_OUT_W-1:0] earlier;
    logic [IDX_OUT_W-1:0] later;
  } pair_result_t;

  typedef struct packed {
    bit           load_target;
    logic [31:0]  target;
    logic [31:0]  word;
    bit           first;
    bit           last;
    bit           typed;
    pair_result_t result;
  } stimulus_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [VAL_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [VAL_W-1:0]     in_value = '0;
  logic                 in_first_of_set = 1'b0;
  logic                 in_last_of_set = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  status_t              out_status;
  logic [IDX_OUT_W-1:0] out_earlier_index;
  logic [IDX_OUT_W-1:0] out_later_index;

  // Model of the hash table.
  longint      target_q;
  int unsigned heads [BUCKET_CNT];
  longint      node_val [SET_CAP];
  int unsigned node_nxt [SET_CAP];
  int unsigned fill;
  bit          closed;

  pair_result_t expected_pairs [$];
  int           mismatch_count;
  int           results_seen;
  int           live_words;
  int           quiet_cycles;
  int unsigned  rx_wait;
  bit           calm;

  // Directed words; typed rows carry a result read straight off the scheme.
  stimulus_row_t directed_rows [25] = '{
    '{1'b0, 32'd0, 32'd5, 1'b0, 1'b0, 1'b1, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'hFFFF_FFFB, 1'b0, 1'b0, 1'b1, '{ST_PAIR, 10'd0, 10'd1}},
    '{1'b0, 32'd0, 32'd7, 1'b0, 1'b1, 1'b1, '{ST_IGNORE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd1, 1'b1, 1'b1, 1'b1, '{ST_END, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd3, 1'b0, 1'b0, 1'b1, '{ST_IGNORE, 10'd0, 10'd0}},
    '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b1, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1, '{ST_PAIR, 10'd1, 10'd2}},
    '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'h8000_0000, 1'b0, 1'b0, 1'b1, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1, '{ST_PAIR, 10'd1, 10'd2}},
    '{1'b0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b1, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, '{ST_END, 10'd0, 10'd0}},
    '{1'b1, 32'd10, 32'd3, 1'b1, 1'b0, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd2050, 1'b0, 1'b0, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd4, 1'b0, 1'b0, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd7, 1'b0, 1'b1, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd3, 1'b1, 1'b0, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd3, 1'b0, 1'b0, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd7, 1'b0, 1'b0, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'hFFFF_FFF6, 1'b1, 1'b0, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd20, 1'b0, 1'b1, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd1, 1'b1, 1'b0, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd9, 1'b1, 1'b0, 1'b0, '{ST_NONE, 10'd0, 10'd0}},
    '{1'b0, 32'd0, 32'd1, 1'b0, 1'b1, 1'b0, '{ST_NONE, 10'd0, 10'd0}}
  };

  hashed_pair_sum_finder #(
    .MAX_ITEMS(SET_CAP),
    .BUCKETS  (BUCKET_CNT)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_first_of_set  (in_first_of_set),
    .in_last_of_set   (in_last_of_set),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_earlier_index(out_earlier_index),
    .out_later_index  (out_later_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bucket of a key: magnitude modulo the bucket count.
  function automatic int unsigned bucket_index(longint key);
    longint mag;
    mag = (key < 0) ? -key : key;
    return int'(mag % BUCKET_CNT);
  endfunction

  // Applies one word to the table model and returns the result it gives.
  function automatic pair_result_t predict_pair(logic [31:0] word, bit first, bit last);
    pair_result_t res;
    longint       v;
    longint       need;
    int unsigned  link;
    int unsigned  steps;
    int unsigned  b;
    bit           hit;
    res = '0;
    v = $signed(word);
    if (first) begin
      foreach (heads[i]) heads[i] = 0;
      fill = 0;
      closed = 1'b0;
    end
    if (closed) begin
      res.status = ST_IGNORE;
    end else if (fill >= SET_CAP) begin
      // Past capacity only the closing word still answers.
      res.status = last ? ST_END : ST_IGNORE;
      if (last) closed = 1'b1;
    end else begin
      need = target_q - v;
      link = heads[bucket_index(need)];
      steps = 0;
      hit = 1'b0;
      // Walk the chain newest first.
      while (link != 0 && !hit && steps < SET_CAP) begin
        if (node_val[link-1] == need) begin
          hit = 1'b1;
          res.earlier = IDX_OUT_W'(link - 1);
        end else begin
          link = node_nxt[link-1];
          steps++;
        end
      end
      if (hit) begin
        res.status = ST_PAIR;
        res.later = IDX_OUT_W'(fill);
        closed = 1'b1;
      end else begin
        b = bucket_index(v);
        node_val[fill] = v;
        node_nxt[fill] = heads[b];
        heads[b] = fill + 1;
        fill++;
        res.status = last ? ST_END : ST_NONE;
        if (last) closed = 1'b1;
      end
    end
    return res;
  endfunction

  // Mix of full random, small, bucket-colliding and extreme words.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      1: return 32'($urandom_range(0, 64)) - 32'd32;
      2: return 32'($urandom_range(0, 7)) + 32'd2047 * 32'($urandom_range(0, 8)) - 32'd8188;
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'd0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Sends one word after a random gap and records the result it must give.
  task automatic feed_word(logic [31:0] word, bit first, bit last, bit typed,
                           pair_result_t typed_result);
    int unsigned  gap;
    pair_result_t predicted;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0 && in_valid) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    predicted = predict_pair(word, first, last);
    expected_pairs.push_back(typed ? typed_result : predicted);
    if (predicted.status != ST_IGNORE) live_words++;
    in_valid        <= 1'b1;
    in_value        <= word;
    in_first_of_set <= first;
    in_last_of_set  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender until every pending result word has come back.
  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  // Writes the target register; only called with the block idle.
  task automatic load_target(logic [31:0] t);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    target_q = $signed(t);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    calm = ($urandom_range(0, 3) == 0);
  endtask

  // A set with one pair planted at random positions.
  task automatic feed_pair_set();
    logic [31:0] words [16];
    int unsigned len;
    int unsigned a;
    int unsigned z;
    longint      partner;
    bit          close_it;
    len = $urandom_range(2, 12);
    a = $urandom_range(0, len - 2);
    z = $urandom_range(a + 1, len - 1);
    for (int k = 0; k < len; k++) words[k] = pick_word();
    partner = target_q - longint'($signed(words[a]));
    if (partner > 64'sd2147483647 || partner < -64'sd2147483648) begin
      words[a] = target_q[31:0];
      partner = 0;
    end
    words[z] = partner[31:0];
    close_it = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < len; k++)
      feed_word(words[k], k == 0, close_it && k == len - 1, 1'b0, '0);
  endtask

  // A set with random words; noisy sets also scatter the set markers.
  task automatic feed_free_set(bit noisy);
    int unsigned len;
    bit          first;
    bit          last;
    len = noisy ? $urandom_range(1, 6) : $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      if (noisy) begin
        first = ($urandom_range(0, 3) == 0);
        last = ($urandom_range(0, 3) == 0);
      end else begin
        first = (k == 0);
        last = (k == len - 1) && $urandom_range(0, 1);
      end
      feed_word(pick_word(), first, last, 1'b0, '0);
    end
  endtask

  // Result side: random stalls per word and comparison with the oldest expectation.
  always @(posedge clk) begin : result_check
    pair_result_t got;
    pair_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_status, out_earlier_index, out_later_index};
        results_seen++;
        if (expected_pairs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d with nothing pending: status %0d earlier %0d later %0d",
                     results_seen, got.status, got.earlier, got.later);
        end else begin
          want = expected_pairs.pop_front();
          if (got.status !== want.status || got.earlier !== want.earlier ||
              got.later !== want.later) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected status %0d earlier %0d later %0d, %s %0d %0d %0d",
                       results_seen, want.status, want.earlier, want.later,
                       "got status/earlier/later", got.status, got.earlier, got.later);
          end
        end
        rx_wait = calm ? 0 : $urandom_range(0, 9);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0);
    end
  end

  // Watchdog on cycles without any word moving.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("hashed_pair_sum_finder: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, starting on the reset target.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].load_target) begin
        drain_results();
        load_target(directed_rows[r].target);
      end
      feed_word(directed_rows[r].word, directed_rows[r].first, directed_rows[r].last,
                directed_rows[r].typed, directed_rows[r].result);
    end

    // Many one-word sets, enough to wrap the set tag of the bucket heads.
    drain_results();
    load_target(pick_word());
    for (int k = 0; k < SINGLE_SETS; k++)
      feed_word(pick_word(), 1'b1, 1'b1, 1'b0, '0);

    // One set past capacity: positive words with a zero target never pair.
    drain_results();
    load_target(32'd0);
    for (int k = 0; k < BIG_SET_LEN; k++)
      feed_word(32'($urandom_range(1, 32'h7FFF_FFFF)), k == 0, k == BIG_SET_LEN - 1,
                1'b0, '0);
    feed_word(pick_word(), 1'b0, 1'b1, 1'b0, '0);

    // Random sets, with a new target now and then.
    while (live_words < WORD_BUDGET) begin
      if ($urandom_range(0, 4) == 0) begin
        drain_results();
        load_target(pick_word());
      end
      case ($urandom_range(0, 4))
        3: feed_free_set(1'b0);
        4: feed_free_set(1'b1);
        default: feed_pair_set();
      endcase
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_pairs.size() == 0)
      $display("hashed_pair_sum_finder: match");
    else
      $display("hashed_pair_sum_finder: mismatch");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/hpsf_pkg.sv
hdl/hashed_pair_sum_finder.sv
tb/tb_hashed_pair_sum_finder.sv
